FILE: hdl/hsm_pkg.sv
// Shared types and constants for the heartbeat session monitor.
package hsm_pkg;

  localparam int NAME_W       = 64;
  localparam int TAIL_W       = 8;
  localparam int HANDLE_W     = 16;
  localparam int MISS_W       = 4;
  localparam int COUNT_W      = 5;
  localparam int NAME_BYTES   = 9;
  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 32;
  localparam int OUT_PAD_W    = OUT_DATA_W - HANDLE_W - 2 * COUNT_W;

  localparam logic [MISS_W-1:0] MISS_LIMIT_RESET = 4'd5;

  typedef enum logic [1:0] {
    REQ_REGISTER  = 2'd0,
    REQ_HEARTBEAT = 2'd1,
    REQ_TICK      = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_ACK        = 3'd2,
    KIND_DROPPED    = 3'd3,
    KIND_TICK_DONE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_CLEAR_MISS,
    OP_BUMP_MISS,
    OP_DROP
  } slot_op_t;

  typedef struct packed {
    logic [NAME_W-1:0]   name_word;
    logic [TAIL_W-1:0]   name_tail;
    logic [HANDLE_W-1:0] handle;
    logic [MISS_W-1:0]   misses;
  } entry_t;

  typedef struct packed {
    logic     load;
    slot_op_t op;
    logic     emit_en;
    kind_t    emit_kind;
    logic     emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_used;
    logic name_hit;
    logic at_limit;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hdl/hsm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module hsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/hsm_ctrl.sv
// Controller that walks the session slots and sequences each request.
module hsm_ctrl
  import hsm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [1:0]                             in_req,
  input  dp_stat_t                               stat,
  output dp_cmd_t                                cmd,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] cur_idx,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_idx
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       req_r, req_nxt;
  logic             accept;
  logic             last_slot;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign last_slot = (idx_r == LAST_IDX);
  assign cur_idx   = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    req_nxt   = req_r;
    rd_idx    = '0;
    cmd       = '{load: 1'b0, op: OP_NONE, emit_en: 1'b0,
                  emit_kind: KIND_REGISTERED, emit_last: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          req_nxt  = in_req;
          idx_nxt  = '0;
          if (in_req == REQ_REGISTER || in_req == REQ_HEARTBEAT || in_req == REQ_TICK) begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_idx = idx_r;
        case (req_r)
          REQ_REGISTER: begin
            if (!stat.slot_used) begin
              if (stat.out_free) begin
                cmd.op        = OP_INSERT;
                cmd.emit_en   = 1'b1;
                cmd.emit_kind = KIND_REGISTERED;
                cmd.emit_last = 1'b1;
                state_nxt     = ST_IDLE;
                rd_idx        = '0;
              end
            end else if (last_slot) begin
              if (stat.out_free) begin
                cmd.emit_en   = 1'b1;
                cmd.emit_kind = KIND_FULL;
                cmd.emit_last = 1'b1;
                state_nxt     = ST_IDLE;
                rd_idx        = '0;
              end
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
              rd_idx  = idx_nxt;
            end
          end
          REQ_HEARTBEAT: begin
            if (stat.slot_used && stat.name_hit) begin
              cmd.op = OP_CLEAR_MISS;
            end
            if (last_slot) begin
              state_nxt = ST_FINISH;
              rd_idx    = '0;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
              rd_idx  = idx_nxt;
            end
          end
          REQ_TICK: begin
            if (stat.slot_used && stat.at_limit && !stat.out_free) begin
              rd_idx = idx_r;
            end else begin
              if (stat.slot_used && stat.at_limit) begin
                cmd.op        = OP_DROP;
                cmd.emit_en   = 1'b1;
                cmd.emit_kind = KIND_DROPPED;
                cmd.emit_last = 1'b0;
              end else if (stat.slot_used) begin
                cmd.op = OP_BUMP_MISS;
              end
              if (last_slot) begin
                state_nxt = ST_FINISH;
                rd_idx    = '0;
              end else begin
                idx_nxt = idx_r + IDX_W'(1);
                rd_idx  = idx_nxt;
              end
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit_en   = 1'b1;
          cmd.emit_kind = (req_r == REQ_HEARTBEAT) ? KIND_ACK : KIND_TICK_DONE;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      req_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      req_r   <= req_nxt;
    end
  end

endmodule

FILE: hdl/hsm_datapath.sv
// Datapath holding the slot table, counters, limit register and result register.
module hsm_datapath
  import hsm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [MISS_W-1:0]                      cfg_wdata,
  input  logic [NAME_W-1:0]                      in_name_word,
  input  logic [TAIL_W-1:0]                      in_name_tail,
  input  logic [HANDLE_W-1:0]                    in_new_handle,
  input  dp_cmd_t                                cmd,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] cur_idx,
  input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rd_idx,
  output dp_stat_t                               stat,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [OUT_DATA_W-1:0]                  out_tdata,
  output logic [2:0]                             out_tuser,
  output logic                                   out_tlast
);

  localparam int ENTRY_W = $bits(entry_t);

  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [MISS_W-1:0]   limit_r;
  logic [COUNT_W-1:0]  live_r, live_nxt;
  logic [COUNT_W-1:0]  match_r, match_nxt;
  logic [NAME_W-1:0]   name_word_r;
  logic [TAIL_W-1:0]   name_tail_r;
  logic [HANDLE_W-1:0] handle_r;

  logic                out_valid_r;
  logic [2:0]          out_kind_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [COUNT_W-1:0]  out_match_r;
  logic [COUNT_W-1:0]  out_live_r;
  logic                out_last_r;

  logic [ENTRY_W-1:0]  ram_q;
  entry_t              slot_q;
  entry_t              wr_entry;
  logic                wr_en;
  logic [8*NAME_BYTES-1:0] slot_name, item_name;
  logic                hit, ended;

  hsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_idx),
    .wdata (wr_entry),
    .raddr (rd_idx),
    .rdata (ram_q)
  );

  assign slot_q    = entry_t'(ram_q);
  assign slot_name = {slot_q.name_tail, slot_q.name_word};
  assign item_name = {name_tail_r, name_word_r};

  // Names compare as zero-terminated strings over the nine bytes.
  always_comb begin
    hit   = 1'b1;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (!ended && (slot_name[8*b +: 8] != item_name[8*b +: 8])) begin
        hit = 1'b0;
      end
      if (slot_name[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
  end

  assign stat.slot_used = valid_r[cur_idx];
  assign stat.name_hit  = hit;
  assign stat.at_limit  = (slot_q.misses == limit_r);
  assign stat.out_free  = !out_valid_r || out_tready;

  always_comb begin
    wr_en     = 1'b0;
    wr_entry  = slot_q;
    valid_nxt = valid_r;
    live_nxt  = live_r;
    match_nxt = cmd.load ? '0 : match_r;
    case (cmd.op)
      OP_INSERT: begin
        wr_en              = 1'b1;
        wr_entry.name_word = name_word_r;
        wr_entry.name_tail = name_tail_r;
        wr_entry.handle    = handle_r;
        wr_entry.misses    = '0;
        valid_nxt[cur_idx] = 1'b1;
        live_nxt           = live_r + COUNT_W'(1);
      end
      OP_CLEAR_MISS: begin
        wr_en           = 1'b1;
        wr_entry.misses = '0;
        match_nxt       = match_r + COUNT_W'(1);
      end
      OP_BUMP_MISS: begin
        wr_en           = 1'b1;
        wr_entry.misses = slot_q.misses + MISS_W'(1);
      end
      OP_DROP: begin
        valid_nxt[cur_idx] = 1'b0;
        live_nxt           = live_r - COUNT_W'(1);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      limit_r     <= MISS_LIMIT_RESET;
      live_r      <= '0;
      match_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      live_r  <= live_nxt;
      match_r <= match_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      name_word_r <= in_name_word;
      name_tail_r <= in_name_tail;
      handle_r    <= in_new_handle;
    end
    if (cmd.emit_en) begin
      out_kind_r   <= cmd.emit_kind;
      out_handle_r <= (cmd.emit_kind == KIND_DROPPED) ? slot_q.handle : '0;
      out_match_r  <= (cmd.emit_kind == KIND_ACK) ? match_r : '0;
      out_live_r   <= live_nxt;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_live_r, out_match_r, out_handle_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: hdl/heartbeat_session_monitor.sv
// Heartbeat session monitor: SLOTS sessions are kept in a slot memory with one read and one
// write port, and every register, heartbeat or tick request walks that memory one slot per
// clock, pausing whenever a result is due while the result register still holds an earlier
// transfer. A register request stops at the lowest free slot, or reports full at the last
// slot. A tick reports each dropped session in slot order, then a closing tick-done
// transfer; a register or heartbeat request gives a single transfer. A request type of 3
// is taken and ignored and gives no transfer. The miss limit may be written only while no
// request is in progress.
module heartbeat_session_monitor
  import hsm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [MISS_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // name_word, name_tail, new_handle
  input  logic [1:0]            in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // dropped_handle, match_count, live_count, zero pad
  output logic [2:0]            out_tuser,  // result_kind
  output logic                  out_tlast
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] rd_idx;

  hsm_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_tuser),
    .stat      (stat),
    .cmd       (cmd),
    .cur_idx   (cur_idx),
    .rd_idx    (rd_idx)
  );

  hsm_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_name_word  (in_tdata[NAME_W-1:0]),
    .in_name_tail  (in_tdata[NAME_W+TAIL_W-1:NAME_W]),
    .in_new_handle (in_tdata[NAME_W+TAIL_W+HANDLE_W-1:NAME_W+TAIL_W]),
    .cmd           (cmd),
    .cur_idx       (cur_idx),
    .rd_idx        (rd_idx),
    .stat          (stat),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast)
  );

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_en |-> stat.out_free)
    else $error("Result loaded while the output register still holds one.");

  a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INSERT) |-> !stat.slot_used)
    else $error("Insert into a slot that is in use.");

  a_drop_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DROP) |-> (stat.slot_used && stat.at_limit && cmd.emit_en))
    else $error("Drop of a slot that is not live at the miss limit.");

  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_NONE) |-> !in_tready)
    else $error("Input ready while a slot walk is in progress.");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the heartbeat session monitor, with a scoreboard of the session table.
module testbench;
  import hsm_pkg::*;

  localparam int SLOTS          = 16;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 3000;
  localparam int MAX_REPORTS    = 40;
  localparam int POOL_SIZE      = 6;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]          kind;
    logic [HANDLE_W-1:0] handle;
    logic [COUNT_W-1:0]  match_cnt;
    logic [COUNT_W-1:0]  live;
    logic                last;
  } session_result_t;

  class session_tracker;
    bit                  valid[SLOTS];
    logic [71:0]         name[SLOTS];
    logic [HANDLE_W-1:0] handle[SLOTS];
    logic [MISS_W-1:0]   misses[SLOTS];
    logic [MISS_W-1:0]   miss_limit;
    session_result_t     pending[$];
    int                  errors;

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      miss_limit = MISS_LIMIT_RESET;
      errors = 0;
    endfunction

    // Names compare like C strings: bytes agree up to and including the first zero byte.
    function bit same_name(logic [71:0] a, logic [71:0] b);
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (a[8*i +: 8] !== b[8*i +: 8]) return 1'b0;
        if (a[8*i +: 8] == 8'd0) return 1'b1;
      end
      return 1'b1;
    endfunction

    function int live_total();
      int n;
      n = 0;
      foreach (valid[i]) if (valid[i]) n++;
      return n;
    endfunction

    function string describe(session_result_t r);
      return $sformatf("kind %0d handle %h matches %0d live %0d last %0b",
                       r.kind, r.handle, r.match_cnt, r.live, r.last);
    endfunction

    function void add_expected(logic [2:0] k, logic [HANDLE_W-1:0] h, int m, int l, bit fin);
      session_result_t r;
      r.kind      = k;
      r.handle    = h;
      r.match_cnt = COUNT_W'(m);
      r.live      = COUNT_W'(l);
      r.last      = fin;
      pending.push_back(r);
    endfunction

    function void take_request(logic [1:0] req, logic [71:0] nm, logic [HANDLE_W-1:0] h);
      bit placed;
      int cleared;
      int live;
      case (req)
        REQ_REGISTER: begin
          placed = 1'b0;
          for (int i = 0; i < SLOTS && !placed; i++) begin
            if (!valid[i]) begin
              valid[i]  = 1'b1;
              name[i]   = nm;
              handle[i] = h;
              misses[i] = '0;
              placed    = 1'b1;
            end
          end
          add_expected(placed ? KIND_REGISTERED : KIND_FULL, '0, 0, live_total(), 1'b1);
        end
        REQ_HEARTBEAT: begin
          cleared = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (valid[i] && same_name(name[i], nm)) begin
              misses[i] = '0;
              cleared++;
            end
          end
          add_expected(KIND_ACK, '0, cleared, live_total(), 1'b1);
        end
        REQ_TICK: begin
          live = live_total();
          for (int i = 0; i < SLOTS; i++) begin
            if (valid[i]) begin
              if (misses[i] == miss_limit) begin
                valid[i] = 1'b0;
                live--;
                add_expected(KIND_DROPPED, handle[i], 0, live, 1'b0);
              end else begin
                misses[i] = misses[i] + 1'b1;
              end
            end
          end
          add_expected(KIND_TICK_DONE, '0, 0, live, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(session_result_t got);
      session_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %s", $time, describe(got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result mismatch, expected %s, got %s",
                   $time, describe(want), describe(got));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [MISS_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // name_word, name_tail, new_handle
  logic [1:0]            in_tuser;   // req_type
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // dropped_handle, match_count, live_count, zero pad
  logic [2:0]            out_tuser;  // result_kind
  logic                  out_tlast;

  bit             tx_idle;
  bit             rx_idle;
  bit             hold_rx;
  logic [71:0]    pool_prefix[POOL_SIZE];
  int             pool_len[POOL_SIZE];
  session_tracker tracker;

  heartbeat_session_monitor #(.SLOTS(SLOTS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.take_request(in_tuser, in_tdata[71:0], in_tdata[87:72]);
      if (out_tvalid && out_tready)
        tracker.check_result({out_tuser, out_tdata[15:0], out_tdata[20:16], out_tdata[25:21],
                              out_tlast});
    end
  end

  initial begin : result_sink
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        out_tready <= !rx_idle || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Most names come from a small pool so that heartbeats find matches; the bytes after the
  // terminating zero are fresh garbage every time.
  function automatic logic [71:0] pick_name();
    logic [71:0] nm;
    int idx;
    nm[63:0]  = {$urandom, $urandom};
    nm[71:64] = 8'($urandom_range(255));
    if ($urandom_range(99) < 25) return nm;
    idx = $urandom_range(POOL_SIZE - 1);
    for (int i = 0; i < pool_len[idx]; i++) nm[8*i +: 8] = pool_prefix[idx][8*i +: 8];
    if (pool_len[idx] < NAME_BYTES) nm[8*pool_len[idx] +: 8] = 8'd0;
    return nm;
  endfunction

  task automatic send_request(logic [1:0] req, logic [71:0] nm, logic [HANDLE_W-1:0] h);
    if (tx_idle && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {h, nm};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [MISS_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.miss_limit = value;
  endtask

  task automatic run_phase(int count, bit with_hold);
    int pick;
    for (int k = 0; k < count; k++) begin
      if (with_hold && k == count / 3) hold_rx = 1'b1;
      pick = $urandom_range(99);
      if (pick < 5) send_request(REQ_UNKNOWN, pick_name(), HANDLE_W'($urandom));
      else if (pick < 40) send_request(REQ_REGISTER, pick_name(), HANDLE_W'($urandom));
      else if (pick < 65) send_request(REQ_HEARTBEAT, pick_name(), HANDLE_W'($urandom));
      else send_request(REQ_TICK, pick_name(), HANDLE_W'($urandom));
    end
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = MISS_LIMIT_RESET;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_REGISTER;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    hold_rx   = 1'b0;
    tracker   = new();
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = (p == 0) ? NAME_BYTES : (p == 1) ? 0 : $urandom_range(1, NAME_BYTES - 1);
      for (int i = 0; i < NAME_BYTES; i++) pool_prefix[p][8*i +: 8] = 8'($urandom_range(1, 255));
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_request(REQ_HEARTBEAT, 72'h0, 16'h0);
    send_request(REQ_TICK, 72'h0, 16'h0);
    send_request(REQ_REGISTER, 72'h5A_1122_3344_0063_6261, 16'hFFFF);
    send_request(REQ_REGISTER, 72'hFF_FFFF_FFFF_FFFF_FFFF, 16'h0000);
    send_request(REQ_REGISTER, 72'hA5_FFEE_DDCC_0063_6261, 16'h1234);
    send_request(REQ_REGISTER, 72'hFF_FFFF_FFFF_FFFF_FF00, 16'h8000);
    send_request(REQ_HEARTBEAT, 72'h00_0000_0000_0063_6261, 16'h0);
    send_request(REQ_HEARTBEAT, 72'hFF_FFFF_FFFF_FFFF_FFFF, 16'h0);
    send_request(REQ_HEARTBEAT, 72'h7F_FFFF_FFFF_FFFF_FFFF, 16'h0);
    send_request(REQ_HEARTBEAT, 72'h0, 16'h0);
    send_request(REQ_UNKNOWN, 72'hFF_FFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_request(REQ_TICK, 72'h0, 16'h0);
    for (int i = 0; i < SLOTS - 4; i++)
      send_request(REQ_REGISTER, pick_name(), HANDLE_W'($urandom));
    send_request(REQ_REGISTER, pick_name(), HANDLE_W'($urandom));

    // Counters climb under a high limit, then keep wrapping once the limit drops below them.
    write_limit(4'd15);
    run_phase(25, 1'b0);
    write_limit(4'd1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_phase(25, 1'b0);
    write_limit(4'd0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_phase(20, 1'b0);
    write_limit(MISS_W'($urandom_range(2, 14)));
    run_phase(25, 1'b1);
    write_limit(MISS_W'($urandom_range(1, 15)));
    run_phase(25, 1'b0);
    write_limit(4'd15);
    run_phase(25, 1'b0);
    settle();

    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
